FILE: sv/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, field widths and command/status codes of the sparse set core.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int IDX_W     = 10;   // variable index and list position
	localparam int CNT_OUT_W = 11;   // member count as reported
	localparam int MAX_IDX   = 1024; // distinct indices an IDX_W field can name

	typedef logic [2:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_INSERT = 3'd0;
	localparam cmd_t CMD_REMOVE = 3'd1;
	localparam cmd_t CMD_CLEAR  = 3'd2;
	localparam cmd_t CMD_QUERY  = 3'd3;
	localparam cmd_t CMD_READ   = 3'd4;

	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_PRESENT     = 2'd1;
	localparam status_t ST_NOT_PRESENT = 2'd2;
	localparam status_t ST_BEYOND      = 2'd3;

endpackage

FILE: sv/sparse_set_membership_core.sv
// ----------------------------------------------------------------------------
// sparse_set_membership_core
// One item in flight: a new item is taken only after the last result has gone
//   to the output register, which waits while the result stream stalls.
// The three steps are the location table read, the dependent member list read
//   and the write-back, all through synchronous memories with registered reads.
// Reset: count clears at once; then the location table is swept, one entry per
//   cycle over min(NUM_VARS, 1024) entries, with the input held off meanwhile.
// Membership is a cross check: index v is present when its recorded slot lies
//   below the count and the list holds v there, so clear is just count = 0.
// ----------------------------------------------------------------------------
module sparse_set_membership_core
	import ssm_pkg::*;
#(
	parameter int NUM_VARS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [9:0] variable_index, [19:10] position, zero pad
	input  logic [2:0]  s_axis_tuser,  // [2:0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [0] present, [11:1] member_count,
	                                   // [21:12] element, [23:22] status
);

	localparam int CAP    = (NUM_VARS < MAX_IDX) ? NUM_VARS : MAX_IDX;
	localparam int SLOT_W = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int CNT_W  = $clog2(CAP + 1);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  count_t;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_LOC,
		S_LIST
	} state_t;

	state_t              state_q;
	slot_t               init_ctr_q;
	count_t              count_q;
	cmd_t                cmd_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    pos_q;
	logic [IDX_W-1:0]    aux_q;      // element for read, last member for remove
	logic                out_valid_q;
	logic [23:0]         out_data_q;

	// location table and member list
	slot_t               loc_mem [CAP];
	logic [IDX_W-1:0]    list_mem [CAP];
	slot_t               loc_rdata_q;
	logic [IDX_W-1:0]    list_rdata_q;

	slot_t               loc_raddr;
	slot_t               list_raddr;
	logic                loc_we;
	slot_t               loc_waddr;
	slot_t               loc_wdata;
	logic                list_we;
	slot_t               list_waddr;
	logic [IDX_W-1:0]    list_wdata;

	logic                in_xfer;
	logic                advance;
	logic                in_range;
	logic                present_now;
	logic                pos_ok;
	logic                insert_ok;
	logic                present_after;
	status_t             status_res;
	logic [IDX_W-1:0]    element_res;
	count_t              count_next;
	slot_t               last_slot;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign advance       = (state_q == S_LIST) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign last_slot   = SLOT_W'(count_q - count_t'(1));
	assign in_range    = (32'(idx_q) < NUM_VARS);
	assign present_now = in_range && (count_t'(loc_rdata_q) < count_q) &&
	                     (list_rdata_q == idx_q);
	assign pos_ok      = (CNT_OUT_W'(pos_q) < CNT_OUT_W'(count_q));
	assign insert_ok   = in_range && !present_now && (32'(count_q) < CAP);

	// read addresses: the input index and either the input position (read) or the
	// last member's slot while idle, then the recorded slot of the held index
	always_comb begin
		loc_raddr  = SLOT_W'(idx_q);
		list_raddr = loc_rdata_q;
		if (state_q == S_IDLE) begin
			loc_raddr  = SLOT_W'(s_axis_tdata[IDX_W-1:0]);
			list_raddr = (s_axis_tuser == CMD_READ) ?
			             SLOT_W'(s_axis_tdata[2*IDX_W-1:IDX_W]) : last_slot;
		end
	end

	always_comb begin
		loc_we        = 1'b0;
		loc_waddr     = init_ctr_q;
		loc_wdata     = '0;
		list_we       = 1'b0;
		list_waddr    = SLOT_W'(count_q);
		list_wdata    = idx_q;
		count_next    = count_q;
		present_after = present_now;
		status_res    = ST_OK;
		element_res   = '0;
		if (state_q == S_INIT) begin
			loc_we = 1'b1;
		end
		case (cmd_q)
			CMD_INSERT: begin
				if (present_now) begin
					status_res = ST_PRESENT;
				end else if (!insert_ok) begin
					status_res = ST_NOT_PRESENT;
				end else begin
					present_after = 1'b1;
					count_next    = count_q + count_t'(1);
					if (advance) begin
						loc_we    = 1'b1;
						loc_waddr = SLOT_W'(idx_q);
						loc_wdata = SLOT_W'(count_q);
						list_we   = 1'b1;
					end
				end
			end
			CMD_REMOVE: begin
				present_after = 1'b0;
				if (!present_now) begin
					status_res = ST_NOT_PRESENT;
				end else begin
					// move the last member into the freed slot
					count_next = count_q - count_t'(1);
					if (advance) begin
						loc_we     = 1'b1;
						loc_waddr  = SLOT_W'(aux_q);
						loc_wdata  = loc_rdata_q;
						list_we    = 1'b1;
						list_waddr = loc_rdata_q;
						list_wdata = aux_q;
					end
				end
			end
			CMD_CLEAR: begin
				present_after = 1'b0;
				count_next    = '0;
			end
			CMD_READ: begin
				if (pos_ok) begin
					element_res = aux_q;
				end else begin
					status_res = ST_BEYOND;
				end
			end
			default: begin
				// query and unused codes change nothing
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (loc_we) begin
			loc_mem[loc_waddr] <= loc_wdata;
		end
		loc_rdata_q <= loc_mem[loc_raddr];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_waddr] <= list_wdata;
		end
		list_rdata_q <= list_mem[list_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_ctr_q  <= '0;
			count_q     <= '0;
			cmd_q       <= CMD_QUERY;
			idx_q       <= '0;
			pos_q       <= '0;
			aux_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (m_axis_tready && !advance) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_ctr_q <= init_ctr_q + slot_t'(1);
					if (init_ctr_q == slot_t'(CAP - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						cmd_q   <= s_axis_tuser;
						idx_q   <= s_axis_tdata[IDX_W-1:0];
						pos_q   <= s_axis_tdata[2*IDX_W-1:IDX_W];
						state_q <= S_LOC;
					end
				end
				S_LOC: begin
					aux_q   <= list_rdata_q;
					state_q <= S_LIST;
				end
				S_LIST: begin
					// hold until the output register is free
					if (advance) begin
						count_q     <= count_next;
						out_valid_q <= 1'b1;
						out_data_q  <= {status_res, element_res,
						                CNT_OUT_W'(count_next), present_after};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAP)
		else $error("member count above capacity");

	a_result_from_list: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_LIST))
		else $error("result raised outside write-back");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_q == CMD_REMOVE && present_now) |=>
		count_q == $past(count_q) - count_t'(1))
		else $error("remove did not shorten the list");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_q == CMD_CLEAR) |=>
		(out_data_q[11:0] == 12'd0) && (count_q == '0))
		else $error("clear left members behind");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse set core. A directed table covers the
// empty set, the index extremes, each command and the error answers. After
// that come mixed random operations on a small index pool, and one pass that
// fills all 1024 indices and drains them again. Each reply is checked field by
// field against its typed answer or a set model. Both stream sides stall at
// random, and once the reply side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top
	import ssm_pkg::*;
();

	localparam cmd_t CMD_SPARE_LO  = 3'd5;
	localparam cmd_t CMD_SPARE_MID = 3'd6;
	localparam cmd_t CMD_SPARE_HI  = 3'd7;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_WAIT  = 20;
	localparam int N_DIRECTED  = 22;

	typedef struct packed {
		logic                 present;
		logic [CNT_OUT_W-1:0] count;
		logic [IDX_W-1:0]     element;
		status_t              status;
	} set_reply_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] pos;
		logic             typed;
		set_reply_t       want;
	} op_row_t;

	// typed rows carry their answer; the rest are checked against the set model
	localparam op_row_t DIRECTED [N_DIRECTED] = '{
		'{CMD_QUERY,      10'd0,    10'd0,    1'b1, '{1'b0, 11'd0, 10'd0, ST_OK}},
		'{CMD_READ,       10'd0,    10'd0,    1'b1, '{1'b0, 11'd0, 10'd0, ST_BEYOND}},
		'{CMD_REMOVE,     10'd1023, 10'd0,    1'b1, '{1'b0, 11'd0, 10'd0, ST_NOT_PRESENT}},
		'{CMD_INSERT,     10'd0,    10'd0,    1'b1, '{1'b1, 11'd1, 10'd0, ST_OK}},
		'{CMD_INSERT,     10'd1023, 10'd0,    1'b1, '{1'b1, 11'd2, 10'd0, ST_OK}},
		'{CMD_INSERT,     10'd0,    10'd0,    1'b1, '{1'b1, 11'd2, 10'd0, ST_PRESENT}},
		'{CMD_READ,       10'd0,    10'd1,    1'b0, '0},
		'{CMD_READ,       10'd1023, 10'd1023, 1'b1, '{1'b1, 11'd2, 10'd0, ST_BEYOND}},
		'{CMD_INSERT,     10'h155,  10'h2aa,  1'b0, '0},
		'{CMD_INSERT,     10'h2aa,  10'h155,  1'b0, '0},
		'{CMD_REMOVE,     10'd0,    10'd0,    1'b0, '0},
		'{CMD_READ,       10'h2aa,  10'd0,    1'b0, '0},
		'{CMD_QUERY,      10'h2aa,  10'h3ff,  1'b0, '0},
		'{CMD_SPARE_LO,   10'h155,  10'd0,    1'b0, '0},
		'{CMD_SPARE_MID,  10'h3ff,  10'h3ff,  1'b0, '0},
		'{CMD_SPARE_HI,   10'h2aa,  10'h155,  1'b0, '0},
		'{CMD_READ,       10'h155,  10'd2,    1'b0, '0},
		'{CMD_CLEAR,      10'h155,  10'h2aa,  1'b0, '0},
		'{CMD_QUERY,      10'd1023, 10'd0,    1'b1, '{1'b0, 11'd0, 10'd0, ST_OK}},
		'{CMD_REMOVE,     10'h2aa,  10'd0,    1'b1, '{1'b0, 11'd0, 10'd0, ST_NOT_PRESENT}},
		'{CMD_INSERT,     10'h2aa,  10'd0,    1'b1, '{1'b1, 11'd1, 10'd0, ST_OK}},
		'{CMD_CLEAR,      10'd0,    10'd0,    1'b1, '{1'b0, 11'd0, 10'd0, ST_OK}}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [9:0] variable_index, [19:10] position, zero pad
	logic [2:0]  s_axis_tuser;   // [2:0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [0] present, [11:1] member_count,
	                             // [21:12] element, [23:22] status

	// set model: membership bit, slot per index, dense member list
	bit in_set [MAX_IDX];
	int slot_at [MAX_IDX];
	int members [MAX_IDX];
	int n_members;

	set_reply_t pending_replies [$];
	int         mismatches = 0;
	int         cycles = 0;
	bit         send_calm;

	sparse_set_membership_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic set_reply_t apply_set_op(cmd_t cmd, logic [IDX_W-1:0] idx,
			logic [IDX_W-1:0] pos);
		set_reply_t r;
		int tail;
		int hole;
		r = '0;
		r.status = ST_OK;
		case (cmd)
		CMD_INSERT: begin
			if (in_set[idx]) begin
				r.status = ST_PRESENT;
			end else if (n_members >= MAX_IDX) begin
				r.status = ST_NOT_PRESENT;
			end else begin
				slot_at[idx] = n_members;
				in_set[idx] = 1'b1;
				members[n_members] = int'(idx);
				n_members++;
			end
		end
		CMD_REMOVE: begin
			if (!in_set[idx] || n_members == 0) begin
				r.status = ST_NOT_PRESENT;
			end else begin
				// move the last member into the freed slot
				tail = members[n_members-1];
				hole = slot_at[idx];
				slot_at[tail] = hole;
				members[hole] = tail;
				n_members--;
				in_set[idx] = 1'b0;
			end
		end
		CMD_CLEAR: begin
			for (int i = 0; i < n_members; i++)
				in_set[members[i]] = 1'b0;
			n_members = 0;
		end
		CMD_READ: begin
			if (pos < n_members)
				r.element = IDX_W'(members[pos]);
			else
				r.status = ST_BEYOND;
		end
		default: ;
		endcase
		r.present = in_set[idx];
		r.count = CNT_OUT_W'(n_members);
		return r;
	endfunction

	task automatic send_op(cmd_t cmd, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] pos,
			logic typed, set_reply_t want);
		int gap;
		set_reply_t pred;
		set_reply_t exp_r;
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {4'b0, pos, idx};
		do @(posedge clk); while (!s_axis_tready);
		pred = apply_set_op(cmd, idx, pos);
		exp_r = typed ? want : pred;
		pending_replies = {pending_replies, exp_r};
	endtask

	// mostly a small index pool so inserts, removes and queries hit each other
	task automatic run_mixed_ops(int n);
		int roll;
		cmd_t cmd;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] pos;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 38)
				cmd = CMD_INSERT;
			else if (roll < 63)
				cmd = CMD_REMOVE;
			else if (roll < 78)
				cmd = CMD_QUERY;
			else if (roll < 94)
				cmd = CMD_READ;
			else if (roll < 97)
				cmd = CMD_CLEAR;
			else
				cmd = CMD_SPARE_LO + cmd_t'($urandom_range(0, 2));
			idx = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, MAX_IDX-1))
			                                  : IDX_W'($urandom_range(0, 23));
			pos = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, MAX_IDX-1))
			      : IDX_W'($urandom_range(0,
			               (n_members < MAX_IDX-1) ? n_members : MAX_IDX-1));
			send_op(cmd, idx, pos, 1'b0, '0);
		end
	endtask

	// fill every index in random order, probe the full set, then empty it
	task automatic fill_and_drain();
		int order [MAX_IDX];
		int j;
		int t;
		send_op(CMD_CLEAR, IDX_W'($urandom_range(0, MAX_IDX-1)), 10'd0, 1'b0, '0);
		for (int i = 0; i < MAX_IDX; i++)
			order[i] = i;
		for (int i = MAX_IDX-1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < MAX_IDX; i++)
			send_op(CMD_INSERT, IDX_W'(order[i]), IDX_W'($urandom_range(0, MAX_IDX-1)),
				1'b0, '0);
		send_op(CMD_READ, IDX_W'($urandom_range(0, MAX_IDX-1)), 10'd1023, 1'b0, '0);
		send_op(CMD_READ, IDX_W'($urandom_range(0, MAX_IDX-1)), 10'd0, 1'b0, '0);
		send_op(CMD_INSERT, IDX_W'($urandom_range(0, MAX_IDX-1)), 10'd0, 1'b0, '0);
		send_op(CMD_QUERY, IDX_W'($urandom_range(0, MAX_IDX-1)), 10'd0, 1'b0, '0);
		repeat (8)
			send_op(CMD_REMOVE, IDX_W'($urandom_range(0, MAX_IDX-1)), 10'd0, 1'b0, '0);
		send_op(CMD_READ, 10'd0, 10'd1023, 1'b0, '0);
		send_op(CMD_CLEAR, 10'd0, 10'd0, 1'b0, '0);
	endtask

	// stimulus and end of run
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_QUERY;
		n_members     = 0;
		send_calm     = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIRECTED; i++)
			send_op(DIRECTED[i].cmd, DIRECTED[i].idx, DIRECTED[i].pos,
				DIRECTED[i].typed, DIRECTED[i].want);
		run_mixed_ops(400);
		fill_and_drain();
		run_mixed_ops(400);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// reply side: random stalls, one long hold-off early in the run
	initial begin
		int gap;
		int taken;
		bit calm;
		bit held;
		m_axis_tready = 1'b0;
		taken = 0;
		calm  = 1'b0;
		held  = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 12);
			if (!held && taken >= 150) begin
				gap  = LONG_HOLD;
				held = 1'b1;
			end
			@(negedge clk);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			taken++;
		end
	end

	// check each reply transfer against the oldest expectation
	always @(posedge clk) begin
		set_reply_t got;
		set_reply_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.present = m_axis_tdata[0];
			got.count   = m_axis_tdata[11:1];
			got.element = m_axis_tdata[21:12];
			got.status  = m_axis_tdata[23:22];
			if (pending_replies.size() == 0) begin
				$error("reply with nothing expected: tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				exp_r = pending_replies.pop_front();
				if (got.present !== exp_r.present) begin
					$error("present: expected %0d, got %0d", exp_r.present, got.present);
					mismatches++;
				end
				if (got.count !== exp_r.count) begin
					$error("member_count: expected %0d, got %0d", exp_r.count, got.count);
					mismatches++;
				end
				if (got.element !== exp_r.element) begin
					$error("element: expected %0d, got %0d", exp_r.element, got.element);
					mismatches++;
				end
				if (got.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, got.status);
					mismatches++;
				end
			end
		end
	end

	// run limit, generous over the reset sweep, stalls and long hold-off
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule

FILE: filelist.f
sv/ssm_pkg.sv
sv/sparse_set_membership_core.sv
verif/tb_top.sv
